// ===== rtl/point_set_bounds_defines.svh =====
// point_set_bounds_defines.svh: assertion macros for the point set bounds block
// no dependencies; included by files that carry assertions
`ifndef POINT_SET_BOUNDS_DEFINES_SVH
`define POINT_SET_BOUNDS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PSB_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define PSB_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/psb_pkg.sv =====
// psb_pkg: types and constants for the point set bounds block
// no dependencies
package psb_pkg;

  localparam int unsigned MaxPoints = 65536;
  localparam int unsigned CoordBits = 32;
  localparam int unsigned SumBits   = 48;
  localparam int unsigned CntBits   = 17;
  localparam int unsigned AccBits   = 66;
  localparam logic [CntBits-1:0] CountMax = '1;

  // one finished set handed from the front to the back
  typedef struct packed {
    logic [2:0][SumBits-1:0]   sum;
    logic [2:0][31:0]          lo;
    logic [2:0][31:0]          hi;
    logic [CntBits-1:0]        count;
    logic                      over;
    logic [1:0]                dims;
  } set_t;

  typedef struct packed {
    logic [31:0] cen_x;
    logic [31:0] cen_y;
    logic [31:0] cen_z;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
    logic [31:0] radius;
    logic [CntBits-1:0] point_count;
    logic too_many;
  } result_t;

  typedef struct packed {
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        last_point;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SQUARE, ST_SQRT, ST_OUT
  } back_state_t;

endpackage

// ===== rtl/psb_if.sv =====
// psb_if: valid/ready channel for points and results
// depends on psb_pkg
interface psb_point_if;
  logic valid;
  logic ready;
  psb_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psb_result_if;
  logic valid;
  logic ready;
  psb_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/psb_front.sv =====
// psb_front: accumulates sums, bounds and count per point
// depends on psb_pkg
module psb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  psb_pkg::point_t    in_data,
  input  logic [1:0]         dims,
  output logic               set_valid,
  input  logic               set_ready,
  output psb_pkg::set_t      set_data
);
  logic [2:0][psb_pkg::SumBits-1:0] sum;
  logic [2:0][31:0] lo, hi;
  logic [psb_pkg::CntBits-1:0] count;
  logic over;
  logic [2:0][31:0] c;
  logic [2:0][31:0] lo_next, hi_next;
  logic [2:0][psb_pkg::SumBits-1:0] sum_next;
  logic [psb_pkg::CntBits-1:0] count_next;
  logic over_next;
  logic take;

  assign c[0] = in_data.coord_x;
  assign c[1] = in_data.coord_y;
  assign c[2] = in_data.coord_z;
  // stall whenever the queue cannot take a finished set, also on points that are not last
  assign in_ready = set_ready;
  assign take = in_valid && in_ready;

  // per-axis update
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_next[a] = (count == '0 || $signed(c[a]) < $signed(lo[a])) ? c[a] : lo[a];
      hi_next[a] = (count == '0 || $signed(c[a]) > $signed(hi[a])) ? c[a] : hi[a];
      sum_next[a] = sum[a] + {{(psb_pkg::SumBits-32){c[a][31]}}, c[a]};
    end
    over_next = over || ({15'd0, count} >= 32'(psb_pkg::MaxPoints));
    count_next = (count < psb_pkg::CountMax) ? count + 1'b1 : count;
  end

  // accumulator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      over  <= 1'b0;
      sum   <= '0;
    end else if (take) begin
      if (in_data.last_point) begin
        count <= '0;
        over  <= 1'b0;
        sum   <= '0;
      end else begin
        count <= count_next;
        over  <= over_next;
        sum   <= sum_next;
      end
    end
    if (take) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  assign set_valid = take && in_data.last_point;
  assign set_data.sum = sum_next;
  assign set_data.lo = lo_next;
  assign set_data.hi = hi_next;
  assign set_data.count = count_next;
  assign set_data.over = over_next;
  assign set_data.dims = (dims == 2'd0) ? 2'd1 : dims;
endmodule

// ===== rtl/psb_queue.sv =====
// psb_queue: two-entry fifo of finished sets between front and back
// depends on psb_pkg
module psb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  psb_pkg::set_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output psb_pkg::set_t rd_data
);
  psb_pkg::set_t mem [2];
  logic wp, rp;
  logic [1:0] fill;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data = mem[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      fill <= fill + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end
endmodule

// ===== rtl/psb_back.sv =====
// psb_back: serial divide for centroids, squares and square root for the radius
// depends on psb_pkg
module psb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          set_valid,
  output logic          set_ready,
  input  psb_pkg::set_t set_data,
  output logic          out_valid,
  input  logic          out_ready,
  output psb_pkg::result_t out_data
);
  psb_pkg::back_state_t state, state_next;
  psb_pkg::set_t cur;
  logic [1:0] axis;
  logic [5:0] step;
  logic [47:0] quo, rem_mag;
  logic [psb_pkg::CntBits:0] rem;
  logic [2:0][31:0] cen;
  logic [psb_pkg::AccBits-1:0] acc, sq_n, sq_res;
  logic neg;
  logic [psb_pkg::CntBits:0] rem_sh, rem_sub;
  logic [32:0] ext, h;
  logic [psb_pkg::AccBits-1:0] sq_bit, sq_try;
  logic [psb_pkg::AccBits-1:0] hsq;
  logic [31:0] cen_sat;
  logic used;

  logic signed [psb_pkg::SumBits-1:0] s_cur;
  assign s_cur = cur.sum[axis];
  assign neg = s_cur[47];
  assign used = axis < cur.dims;

  // one quotient bit a cycle
  assign rem_sh = {rem[psb_pkg::CntBits-1:0], rem_mag[47]};
  assign rem_sub = rem_sh - {1'b0, cur.count};
  // saturated signed centroid from magnitude quotient
  always_comb begin
    logic [47:0] qf;
    qf = {quo[46:0], ~rem_sub[psb_pkg::CntBits]};
    if (neg) cen_sat = (qf > 48'h80000000) ? 32'h80000000 : 32'(-qf);
    else cen_sat = (qf > 48'h7FFFFFFF) ? 32'h7FFFFFFF : qf[31:0];
  end

  // half extent square for the current axis
  assign ext = {cur.hi[axis][31], cur.hi[axis]} - {cur.lo[axis][31], cur.lo[axis]};
  assign h = {1'b0, ext[32:1]};
  assign hsq = 66'(h * h) + 66'(ext[0] ? h : 33'd0);

  // square root: two bits of radicand a cycle
  assign sq_bit = 66'd1 << {step, 1'b0};
  assign sq_try = sq_res + sq_bit;

  always_comb begin
    state_next = state;
    case (state)
      psb_pkg::ST_IDLE:   if (set_valid) state_next = psb_pkg::ST_DIV;
      psb_pkg::ST_DIV:    if (step == 6'd47 && axis == 2'd2) state_next = psb_pkg::ST_SQUARE;
      psb_pkg::ST_SQUARE: if (axis == 2'd2) state_next = psb_pkg::ST_SQRT;
      psb_pkg::ST_SQRT:   if (step == 6'd0) state_next = psb_pkg::ST_OUT;
      psb_pkg::ST_OUT:    if (out_ready) state_next = psb_pkg::ST_IDLE;
      default:            state_next = psb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    set_ready = state == psb_pkg::ST_IDLE;
    out_valid = state == psb_pkg::ST_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= psb_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      psb_pkg::ST_IDLE: begin
        cur <= set_data;
        axis <= '0;
        step <= '0;
        rem <= '0;
        quo <= '0;
        rem_mag <= set_data.sum[0][47] ? 48'(-set_data.sum[0]) : set_data.sum[0];
        acc <= '0;
      end
      psb_pkg::ST_DIV: begin
        if (step == 6'd47) begin
          cen[axis] <= used ? cen_sat : 32'd0;
          step <= '0;
          rem <= '0;
          quo <= '0;
          if (axis != 2'd2) begin
            axis <= axis + 1'b1;
            rem_mag <= cur.sum[axis + 1'b1][47] ? 48'(-cur.sum[axis + 1'b1])
                                                : cur.sum[axis + 1'b1];
          end else begin
            axis <= '0;
          end
        end else begin
          rem <= rem_sub[psb_pkg::CntBits] ? rem_sh : rem_sub;
          quo <= {quo[46:0], ~rem_sub[psb_pkg::CntBits]};
          rem_mag <= {rem_mag[46:0], 1'b0};
          step <= step + 1'b1;
        end
      end
      psb_pkg::ST_SQUARE: begin
        if (used) acc <= acc + hsq;
        axis <= axis + 1'b1;
        if (axis == 2'd2) begin
          // quarter terms of odd extents sum to less than one over three axes
          sq_n <= used ? acc + hsq : acc;
          sq_res <= '0;
          step <= 6'd32;
        end
      end
      psb_pkg::ST_SQRT: begin
        if (sq_n >= sq_try) begin
          sq_n <= sq_n - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        step <= step - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data.cen_x = cen[0];
    out_data.cen_y = cen[1];
    out_data.cen_z = cen[2];
    out_data.min_x = cur.lo[0];
    out_data.min_y = (cur.dims >= 2'd2) ? cur.lo[1] : 32'd0;
    out_data.min_z = (cur.dims == 2'd3) ? cur.lo[2] : 32'd0;
    out_data.max_x = cur.hi[0];
    out_data.max_y = (cur.dims >= 2'd2) ? cur.hi[1] : 32'd0;
    out_data.max_z = (cur.dims == 2'd3) ? cur.hi[2] : 32'd0;
    out_data.radius = sq_res[31:0];
    out_data.point_count = cur.count;
    out_data.too_many = cur.over;
  end
endmodule

// ===== rtl/point_set_bounds.sv =====
// point_set_bounds: top level, front accumulator, set queue and back end
// depends on psb_pkg, psb_if, psb_front, psb_queue, psb_back and the defines header
// Points are taken one a cycle while the queue has room; sums, bounds and
// the count update in the front. On a last point the set enters a two-entry
// queue, and the back end loads it, runs a serial divide per axis, then the
// squares and the square root, and hands the result over. Sets that arrive
// faster than the back end finishes them back up into the queue. The front
// stalls only when the queue holds two sets. The dimensions register is
// sampled with the last point.
`include "point_set_bounds_defines.svh"
module point_set_bounds (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_data,
  psb_point_if.sink    pts,
  psb_result_if.source res
);
  logic [1:0] dims;
  logic q_wv, q_wr, q_rv, q_rr;
  psb_pkg::set_t q_wd, q_rd;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) dims <= 2'd3;
    else if (cfg_we) dims <= cfg_data;
  end

  psb_front u_front (.clk, .rst, .in_valid(pts.valid), .in_ready(pts.ready),
    .in_data(pts.data), .dims, .set_valid(q_wv), .set_ready(q_wr), .set_data(q_wd));
  psb_queue u_queue (.clk, .rst, .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_wd),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_data(q_rd));
  psb_back u_back (.clk, .rst, .set_valid(q_rv), .set_ready(q_rr), .set_data(q_rd),
    .out_valid(res.valid), .out_ready(res.ready), .out_data(res.data));

  `PSB_ASSERT_IMP(a_full_stall, clk, rst, !q_wr, !pts.ready)
  `PSB_ASSERT_NEXT(a_out_hold, clk, rst, res.valid && !res.ready, res.valid)
  `PSB_ASSERT_IMP(a_cnt_range, clk, rst, res.valid, res.data.point_count != 17'd0)
endmodule

// ===== tb/tb.sv =====
// tb: testbench for point_set_bounds, random points with a software predictor
// depends on psb_pkg, psb_if and the point_set_bounds rtl
module tb;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_data;

  psb_point_if pts ();
  psb_result_if res ();

  point_set_bounds DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .pts(pts.sink), .res(res.source)
  );

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state
  logic [1:0] dims_cfg;
  logic [psb_pkg::SumBits-1:0] acc_sum [3];
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic [psb_pkg::CntBits-1:0] set_points;
  logic set_over;

  psb_pkg::point_t pending_points [$];
  psb_pkg::result_t expected_results [$];
  int errors;
  int src_idle_pct, snk_idle_pct;
  int hold_cycles;

  function automatic logic [31:0] floor_sqrt(logic [psb_pkg::AccBits-1:0] n);
    logic [psb_pkg::AccBits-1:0] r;
    logic [psb_pkg::AccBits-1:0] b;
    r = '0;
    b = {2'b01, {(psb_pkg::AccBits-2){1'b0}}};
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] mean_of(logic [psb_pkg::SumBits-1:0] s,
                                          logic [psb_pkg::CntBits-1:0] n);
    logic signed [psb_pkg::SumBits-1:0] sv;
    logic [psb_pkg::SumBits-1:0] mag;
    logic [psb_pkg::SumBits-1:0] q;
    sv = s;
    mag = sv < 0 ? -sv : sv;
    q = mag / n;
    if (sv < 0) return q > 48'h80000000 ? 32'h80000000 : 32'(-q);
    return q > 48'h7fffffff ? 32'h7fffffff : q[31:0];
  endfunction

  function automatic void clear_set();
    for (int a = 0; a < 3; a++) begin
      acc_sum[a] = '0;
      box_lo[a] = '0;
      box_hi[a] = '0;
    end
    set_points = '0;
    set_over = 1'b0;
  endfunction

  // update running sums, bounds and count and, on a last point, queue the expected result
  function automatic void predict_point(psb_pkg::point_t p);
    logic signed [31:0] c [3];
    logic [psb_pkg::AccBits-1:0] sq;
    logic [33:0] e, h;
    int odd, used;
    psb_pkg::result_t r;
    c[0] = p.coord_x; c[1] = p.coord_y; c[2] = p.coord_z;
    for (int a = 0; a < 3; a++) begin
      if (set_points == 0 || c[a] < box_lo[a]) box_lo[a] = c[a];
      if (set_points == 0 || c[a] > box_hi[a]) box_hi[a] = c[a];
      acc_sum[a] = acc_sum[a] + {{(psb_pkg::SumBits-32){c[a][31]}}, c[a]};
    end
    if (set_points >= psb_pkg::MaxPoints) set_over = 1'b1;
    if (set_points != psb_pkg::CountMax) set_points = set_points + 1'b1;
    if (!p.last_point) return;
    used = dims_cfg == 0 ? 1 : dims_cfg;
    sq = '0;
    odd = 0;
    r = '0;
    for (int a = 0; a < used; a++) begin
      e = 34'($signed({box_hi[a][31], box_hi[a]}) - $signed({box_lo[a][31], box_lo[a]}));
      h = e >> 1;
      sq = sq + psb_pkg::AccBits'(h) * psb_pkg::AccBits'(h)
           + (e[0] ? psb_pkg::AccBits'(h) : '0);
      odd = odd + e[0];
    end
    sq = sq + (odd >> 2);
    if (used > 0) begin
      r.cen_x = mean_of(acc_sum[0], set_points); r.min_x = box_lo[0]; r.max_x = box_hi[0];
    end
    if (used > 1) begin
      r.cen_y = mean_of(acc_sum[1], set_points); r.min_y = box_lo[1]; r.max_y = box_hi[1];
    end
    if (used > 2) begin
      r.cen_z = mean_of(acc_sum[2], set_points); r.min_z = box_lo[2]; r.max_z = box_hi[2];
    end
    r.radius = floor_sqrt(sq);
    r.point_count = set_points;
    r.too_many = set_over;
    expected_results.push_back(r);
    clear_set();
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 200) - 100;
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_set(int n, logic [31:0] fixed_val, bit use_fixed);
    psb_pkg::point_t p;
    for (int i = 0; i < n; i++) begin
      p.coord_x = use_fixed ? fixed_val : rand_coord();
      p.coord_y = use_fixed ? ~fixed_val : rand_coord();
      p.coord_z = use_fixed ? fixed_val : rand_coord();
      p.last_point = (i == n - 1);
      pending_points.push_back(p);
    end
  endtask

  task automatic write_dims(logic [1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dims_cfg = v;
  endtask

  // wait until the block has drained everything sent so far
  task automatic drain();
    while (pending_points.size() != 0 || pts.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      pts.valid <= 1'b0;
    end else begin
      if (pts.valid && pts.ready) predict_point(pts.data);
      if ((!pts.valid || pts.ready) && pending_points.size() != 0
          && $urandom_range(0, 99) >= src_idle_pct) begin
        pts.data <= pending_points.pop_front();
        pts.valid <= 1'b1;
      end else if (pts.valid && pts.ready) begin
        pts.valid <= 1'b0;
      end
    end
  end

  // result monitor and ready driver
  always @(posedge clk) begin
    psb_pkg::result_t exp_r, got;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = res.data;
        if (expected_results.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.cen_x !== exp_r.cen_x) begin
            $error("cen_x exp %h got %h", exp_r.cen_x, got.cen_x); errors++; end
          if (got.cen_y !== exp_r.cen_y) begin
            $error("cen_y exp %h got %h", exp_r.cen_y, got.cen_y); errors++; end
          if (got.cen_z !== exp_r.cen_z) begin
            $error("cen_z exp %h got %h", exp_r.cen_z, got.cen_z); errors++; end
          if (got.min_x !== exp_r.min_x) begin
            $error("min_x exp %h got %h", exp_r.min_x, got.min_x); errors++; end
          if (got.min_y !== exp_r.min_y) begin
            $error("min_y exp %h got %h", exp_r.min_y, got.min_y); errors++; end
          if (got.min_z !== exp_r.min_z) begin
            $error("min_z exp %h got %h", exp_r.min_z, got.min_z); errors++; end
          if (got.max_x !== exp_r.max_x) begin
            $error("max_x exp %h got %h", exp_r.max_x, got.max_x); errors++; end
          if (got.max_y !== exp_r.max_y) begin
            $error("max_y exp %h got %h", exp_r.max_y, got.max_y); errors++; end
          if (got.max_z !== exp_r.max_z) begin
            $error("max_z exp %h got %h", exp_r.max_z, got.max_z); errors++; end
          if (got.radius !== exp_r.radius) begin
            $error("radius exp %h got %h", exp_r.radius, got.radius); errors++; end
          if (got.point_count !== exp_r.point_count) begin
            $error("point_count exp %h got %h", exp_r.point_count, got.point_count);
            errors++;
          end
          if (got.too_many !== exp_r.too_many) begin
            $error("too_many exp %h got %h", exp_r.too_many, got.too_many); errors++; end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= $urandom_range(0, 99) >= snk_idle_pct;
      end
    end
  end

  // run limit
  initial begin
    #60000000;
    $display("tb: errors");
    $finish;
  end

  // stimulus
  initial begin
    errors = 0;
    hold_cycles = 0;
    src_idle_pct = 11;
    snk_idle_pct = 74;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 2'd0;
    pts.valid = 1'b0;
    pts.data = '0;
    res.ready = 1'b0;
    dims_cfg = 2'd3;
    clear_set();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: single points at the extremes, small sets
    add_set(1, 32'h7fffffff, 1);
    add_set(1, 32'h80000000, 1);
    add_set(2, 32'h80000000, 1);
    add_set(1, 32'h00000000, 1);
    pending_points.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 1'b0});
    pending_points.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1});
    add_set(3, 0, 0);
    add_set(5, 0, 0);
    drain();

    // dimension zero, one and two
    write_dims(2'd0);
    add_set(3, 0, 0);
    drain();
    write_dims(2'd1);
    add_set(4, 0, 0);
    drain();
    write_dims(2'd2);
    add_set(2, 0, 0);
    // long receiver hold while points keep coming
    hold_cycles = 800;
    for (int i = 0; i < 12; i++) add_set(2, 0, 0);
    drain();

    // random sets, three idling phases and changing dimensions
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = ph == 0 ? 11 : (ph == 1 ? 74 : 0);
      snk_idle_pct = ph == 0 ? 74 : (ph == 1 ? 11 : 0);
      write_dims(ph == 1 ? 2'd1 : 2'd3);
      for (int k = 0; k < 3; k++) begin
        for (int s = 0; s < 22; s++) begin
          int n;
          n = $urandom_range(0, 3) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 8);
          add_set(n, 0, 0);
        end
        // change dimensions mid-set: last point decides
        add_set(1, 0, 0);
        pending_points.push_back('{rand_coord(), rand_coord(), rand_coord(), 1'b0});
        drain();
        write_dims(2'($urandom_range(1, 3)));
        pending_points.push_back('{rand_coord(), rand_coord(), rand_coord(), 1'b1});
        drain();
      end
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
